### rtl/core/mcdt_pkg.sv
// Shared types, codes and constants of the multi-channel delay timer.
`timescale 1ns / 1ps

package mcdt_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int RESULT_LIMIT = 2;

  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_STATUS    = 3'd1;
  localparam logic [2:0] CMD_ON_DELAY  = 3'd2;
  localparam logic [2:0] CMD_OFF_DELAY = 3'd3;
  localparam logic [2:0] CMD_ON_TIMED  = 3'd4;
  localparam logic [2:0] CMD_ABORT     = 3'd5;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ON     = 3'd1;
  localparam logic [2:0] EV_OFF    = 3'd2;
  localparam logic [2:0] EV_ABORT  = 3'd3;
  localparam logic [2:0] EV_STATUS = 3'd4;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON   = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;

  typedef struct packed {
    logic [3:0] channel;
    logic [2:0] event_res;
    logic       state;
    logic       error;
  } res_t;

endpackage

### rtl/core/mcdt_if.sv
// Valid/ready channel interfaces for timer commands and timer results.
`timescale 1ns / 1ps

interface mcdt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  channel;
  logic [31:0] now_ms;
  logic [31:0] delay_ms;
  logic        report_status;

  modport source (output valid, cmd, channel, now_ms, delay_ms, report_status,
                  input ready);
  modport sink (input valid, cmd, channel, now_ms, delay_ms, report_status,
                output ready);
endinterface

interface mcdt_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_channel;
  logic [2:0] event_res;
  logic       out_state;
  logic       error;
  logic       last;

  modport source (output valid, out_channel, event_res, out_state, error, last,
                  input ready);
  modport sink (input valid, out_channel, event_res, out_state, error, last,
                output ready);
endinterface

### rtl/core/multi_channel_delay_timer_top.sv
// Multi-channel delay timer: command decode, channel walk and result queue.
// A command passes through S_EXEC to S_OUT and gives its one result beat there.
// A tick walks one channel per cycle through the shared 32-bit adder, stopping
// after the last channel or at the second result, then gives one beat per cycle
// while rsp.ready is high. A new item is taken only in S_IDLE, once all beats are out.
// Reset is synchronous: all outputs off, no actions pending, no beat queued.
`timescale 1ns / 1ps

module multi_channel_delay_timer_top
  import mcdt_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mcdt_cmd_if.sink     req,
  mcdt_res_if.source   rsp
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(RESULT_LIMIT + 1);
  localparam int SLOT_W = (RESULT_LIMIT > 1) ? $clog2(RESULT_LIMIT) : 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_EXEC, S_OUT} state_t;

  state_t              state;
  logic [2:0]          cmd;
  logic [3:0]          chan;
  logic [31:0]         now;
  logic [31:0]         dly;
  logic                rep;
  logic [CH_W-1:0]     idx;
  logic [CNT_W-1:0]    nres;
  logic [SLOT_W-1:0]   emit;
  res_t                slot [RESULT_LIMIT];

  logic [CHANNELS-1:0] output_on;
  logic [1:0]          pend [CHANNELS];
  logic [31:0]         deadline [CHANNELS];

  logic                ch_ok;
  logic [CH_W-1:0]     addr;
  logic                rd_on;
  logic [1:0]          rd_act;
  logic [31:0]         alu_b;
  logic                alu_cin;
  logic [31:0]         alu_sum;
  logic                expired;
  logic                walk_hit;
  logic                walk_chg;
  logic                walk_on;
  logic [CNT_W-1:0]    nres_next;
  logic                is_last;
  res_t                exec_res;

  assign ch_ok   = {1'b0, chan} < 5'(CHANNELS);
  assign addr    = (state == S_WALK) ? idx : (ch_ok ? chan[CH_W-1:0] : '0);
  assign rd_on   = output_on[addr];
  assign rd_act  = pend[addr];

  assign alu_b   = (state == S_WALK) ? ~deadline[addr] : dly;
  assign alu_cin = (state == S_WALK);
  assign alu_sum = now + alu_b + {31'd0, alu_cin};

  assign expired   = ~alu_sum[31];
  assign walk_hit  = ((rd_act == ACT_ON) || (rd_act == ACT_OFF)) && expired;
  assign walk_on   = (rd_act == ACT_ON);
  assign walk_chg  = walk_hit && (rd_on != walk_on);
  assign nres_next = nres + CNT_W'(walk_chg);

  assign is_last   = (CNT_W'(emit) + CNT_W'(1)) == nres;

  always_comb begin
    exec_res.channel   = chan;
    exec_res.event_res = EV_NONE;
    exec_res.state     = ch_ok ? rd_on : 1'b0;
    exec_res.error     = !ch_ok;
    if (ch_ok) begin
      unique case (cmd)
        CMD_STATUS: begin
          exec_res.event_res = rep ? EV_STATUS : EV_NONE;
        end
        CMD_ON_DELAY, CMD_OFF_DELAY: begin
          exec_res.event_res = EV_NONE;
        end
        CMD_ON_TIMED: begin
          exec_res.state     = 1'b1;
          exec_res.event_res = rd_on ? EV_NONE : EV_ON;
        end
        CMD_ABORT: begin
          exec_res.event_res = EV_ABORT;
        end
        default: begin
          exec_res.error = 1'b1;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_OUT);
  assign rsp.out_channel = slot[emit].channel;
  assign rsp.event_res   = slot[emit].event_res;
  assign rsp.out_state   = slot[emit].state;
  assign rsp.error       = slot[emit].error;
  assign rsp.last        = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      output_on <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pend[i]     <= ACT_NONE;
        deadline[i] <= '0;
      end
      nres      <= '0;
      emit      <= '0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd   <= req.cmd;
            chan  <= req.channel;
            now   <= req.now_ms;
            dly   <= req.delay_ms;
            rep   <= req.report_status;
            idx   <= '0;
            nres  <= '0;
            emit  <= '0;
            state <= (req.cmd == CMD_TICK) ? S_WALK : S_EXEC;
          end
        end
        S_WALK: begin
          if (walk_hit) begin
            pend[idx]      <= ACT_NONE;
            output_on[idx] <= walk_on;
          end
          if (walk_chg) begin
            slot[nres[SLOT_W-1:0]] <= '{channel:   4'(idx),
                                       event_res: walk_on ? EV_ON : EV_OFF,
                                       state:     walk_on,
                                       error:     1'b0};
          end
          nres <= nres_next;
          if ((idx == CH_W'(CHANNELS - 1)) || (nres_next == CNT_W'(RESULT_LIMIT))) begin
            state <= (nres_next != '0) ? S_OUT : S_IDLE;
          end else begin
            idx <= idx + CH_W'(1);
          end
        end
        S_EXEC: begin
          slot[0] <= exec_res;
          nres    <= CNT_W'(1);
          state   <= S_OUT;
          if (ch_ok) begin
            unique case (cmd)
              CMD_ON_DELAY: begin
                pend[addr]     <= ACT_ON;
                deadline[addr] <= alu_sum;
              end
              CMD_OFF_DELAY: begin
                pend[addr]     <= ACT_OFF;
                deadline[addr] <= alu_sum;
              end
              CMD_ON_TIMED: begin
                pend[addr]      <= ACT_OFF;
                deadline[addr]  <= alu_sum;
                output_on[addr] <= 1'b1;
              end
              CMD_ABORT: begin
                pend[addr]     <= ACT_NONE;
                deadline[addr] <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              emit <= emit + SLOT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready)
    else $error("result beat shown while taking a new item");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    nres <= CNT_W'(RESULT_LIMIT))
    else $error("result count beyond limit");

  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (nres != '0))
    else $error("output state with no queued result");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready held after accepting an item");

  a_cmd_one_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (rsp.valid && rsp.last))
    else $error("command did not give a single final beat");

endmodule

### test/multi_channel_delay_timer_top_tb.sv
// Self-checking testbench for the multi-channel delay timer with a built-in predictor.
`timescale 1ns / 1ps

module multi_channel_delay_timer_top_tb;
  import mcdt_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam logic [2:0] CMD_BAD_LO = 3'd6;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam int MODE_OPEN = 0;
  localparam int MODE_HALF = 1;
  localparam int MODE_SPARSE = 2;
  localparam int HOLD_CYCLES = 160;
  localparam int RANDOM_ITEMS = 960;

  typedef struct {
    logic [2:0]  cmd;
    logic [3:0]  channel;
    logic [31:0] now_ms;
    logic [31:0] delay_ms;
    logic        report_status;
    bit          drain_first;
  } timer_cmd_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [2:0] ev;
    logic       state;
    logic       error;
    logic       last;
  } relay_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcdt_cmd_if cmd_bus ();
  mcdt_res_if res_bus ();

  multi_channel_delay_timer_top #(.CHANNELS(NCH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (cmd_bus),
    .rsp (res_bus)
  );

  always #10 clk = ~clk;

  timer_cmd_t  cmd_backlog[$];
  relay_beat_t expected_beats[$];

  logic        relay_on  [NCH];
  logic [1:0]  relay_act [NCH];
  logic [31:0] relay_due [NCH];

  logic cmd_taken = 1'b0;
  int   items_taken = 0;
  int   beats_checked = 0;
  int   switch_beats = 0;
  int   error_beats = 0;
  int   mismatches = 0;
  int   holds_done = 0;
  int   drain_pauses = 0;

  task automatic flag_mismatch(input string what);
    if (mismatches < 20) $display("MISMATCH at beat %0d: %s", beats_checked, what);
    mismatches++;
  endtask

  task automatic add_item(input logic [2:0] cmd, input logic [3:0] ch,
                          input logic [31:0] now, input logic [31:0] dly,
                          input logic rep, input bit drain);
    timer_cmd_t c;
    c.cmd = cmd;
    c.channel = ch;
    c.now_ms = now;
    c.delay_ms = dly;
    c.report_status = rep;
    c.drain_first = drain;
    if (drain) drain_pauses++;
    cmd_backlog.push_back(c);
  endtask

  task automatic timer_predict(input timer_cmd_t c);
    relay_beat_t b;
    relay_beat_t fired [RESULT_LIMIT];
    logic [1:0]  act;
    logic [31:0] lag;
    int          n;
    n = 0;
    if (c.cmd == CMD_TICK) begin
      for (int i = 0; i < NCH && n < RESULT_LIMIT; i++) begin
        act = relay_act[i];
        lag = c.now_ms - relay_due[i];
        if ((act == ACT_ON || act == ACT_OFF) && !lag[31]) begin
          relay_act[i] = ACT_NONE;
          if (relay_on[i] != (act == ACT_ON)) begin
            relay_on[i] = (act == ACT_ON);
            fired[n].channel = i[3:0];
            fired[n].ev = relay_on[i] ? EV_ON : EV_OFF;
            fired[n].state = relay_on[i];
            fired[n].error = 1'b0;
            fired[n].last = 1'b0;
            n++;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        b = fired[k];
        b.last = (k == n - 1);
        expected_beats.push_back(b);
      end
    end else begin
      b.channel = c.channel;
      b.ev = EV_NONE;
      b.state = 1'b0;
      b.error = 1'b0;
      b.last = 1'b1;
      if (c.channel >= NCH) begin
        b.error = 1'b1;
      end else begin
        case (c.cmd)
          CMD_STATUS: b.ev = c.report_status ? EV_STATUS : EV_NONE;
          CMD_ON_DELAY: begin
            relay_act[c.channel] = ACT_ON;
            relay_due[c.channel] = c.now_ms + c.delay_ms;
          end
          CMD_OFF_DELAY: begin
            relay_act[c.channel] = ACT_OFF;
            relay_due[c.channel] = c.now_ms + c.delay_ms;
          end
          CMD_ON_TIMED: begin
            relay_act[c.channel] = ACT_OFF;
            relay_due[c.channel] = c.now_ms + c.delay_ms;
            if (!relay_on[c.channel]) begin
              relay_on[c.channel] = 1'b1;
              b.ev = EV_ON;
            end
          end
          CMD_ABORT: begin
            relay_act[c.channel] = ACT_NONE;
            relay_due[c.channel] = '0;
            b.ev = EV_ABORT;
          end
          default: b.error = 1'b1;
        endcase
        b.state = relay_on[c.channel];
      end
      expected_beats.push_back(b);
    end
  endtask

  // predict on accepted commands, check result beats
  always @(posedge clk) begin
    timer_cmd_t  c;
    relay_beat_t want;
    cmd_taken <= cmd_bus.valid && cmd_bus.ready;
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        relay_on[i] = 1'b0;
        relay_act[i] = ACT_NONE;
        relay_due[i] = '0;
      end
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        c.cmd = cmd_bus.cmd;
        c.channel = cmd_bus.channel;
        c.now_ms = cmd_bus.now_ms;
        c.delay_ms = cmd_bus.delay_ms;
        c.report_status = cmd_bus.report_status;
        c.drain_first = 1'b0;
        timer_predict(c);
        items_taken++;
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          if (res_bus.out_channel !== want.channel)
            flag_mismatch($sformatf("out_channel %0d, want %0d",
                                    res_bus.out_channel, want.channel));
          if (res_bus.event_res !== want.ev)
            flag_mismatch($sformatf("event_res %0d, want %0d",
                                    res_bus.event_res, want.ev));
          if (res_bus.out_state !== want.state)
            flag_mismatch($sformatf("out_state %0b, want %0b",
                                    res_bus.out_state, want.state));
          if (res_bus.error !== want.error)
            flag_mismatch($sformatf("error %0b, want %0b", res_bus.error, want.error));
          if (res_bus.last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", res_bus.last, want.last));
          if (want.ev == EV_ON || want.ev == EV_OFF) switch_beats++;
          if (want.error) error_beats++;
        end
        beats_checked++;
      end
    end
  end

  // command driver: bursts with gaps, drain pauses on flagged items
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    timer_cmd_t c;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (cmd_bus.valid && !cmd_taken) begin
      cmd_bus.valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      cmd_bus.valid <= 1'b0;
    end else if (cmd_backlog.size() == 0) begin
      cmd_bus.valid <= 1'b0;
    end else if (cmd_backlog[0].drain_first && expected_beats.size() != 0) begin
      cmd_bus.valid <= 1'b0;
    end else begin
      c = cmd_backlog.pop_front();
      cmd_bus.cmd <= c.cmd;
      cmd_bus.channel <= c.channel;
      cmd_bus.now_ms <= c.now_ms;
      cmd_bus.delay_ms <= c.delay_ms;
      cmd_bus.report_status <= c.report_status;
      cmd_bus.valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // result receiver: stall patterns plus long hold-offs
  int mode = MODE_OPEN;
  int mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 250;

  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && items_taken >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 400;
        holds_done++;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(MODE_OPEN, MODE_SPARSE);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (mode == MODE_OPEN) begin
        res_bus.ready <= 1'b1;
      end else if (mode == MODE_HALF) begin
        res_bus.ready <= ($urandom_range(0, 1) == 1);
      end else begin
        res_bus.ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    logic [31:0] clock_ms;
    logic [31:0] dly;
    logic [3:0]  ch;
    logic [2:0]  op;
    int          pick;

    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = CMD_TICK;
    cmd_bus.channel = '0;
    cmd_bus.now_ms = '0;
    cmd_bus.delay_ms = '0;
    cmd_bus.report_status = 1'b0;
    res_bus.ready = 1'b0;

    add_item(CMD_STATUS, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_STATUS, 4'd1, 32'd0, 32'd0, 1'b1, 1'b0);
    add_item(CMD_BAD_LO, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_BAD_HI, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_item(CMD_ON_DELAY, 4'd2, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ABORT, 4'd15, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_DELAY, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_TIMED, 4'd0, 32'd5, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_TIMED, 4'd1, 32'd100, 32'd50, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd9, 32'd149, 32'd0, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'd150, 32'd0, 1'b0, 1'b0);
    add_item(CMD_OFF_DELAY, 4'd1, 32'd200, 32'd0, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'd200, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_DELAY, 4'd0, 32'hFFFF_FFF0, 32'h20, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'h10, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_DELAY, 4'd1, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
    add_item(CMD_OFF_DELAY, 4'd0, 32'd0, 32'h8000_0000, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'hFFFF_FFFE, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_DELAY, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ABORT, 4'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    add_item(CMD_OFF_DELAY, 4'd1, 32'd5, 32'd0, 1'b0, 1'b0);
    add_item(CMD_ON_DELAY, 4'd0, 32'd5, 32'd0, 1'b0, 1'b0);
    add_item(CMD_TICK, 4'd0, 32'd5, 32'd0, 1'b0, 1'b0);

    clock_ms = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      clock_ms += $urandom_range(0, 20);
      if ($urandom_range(0, 199) == 0) clock_ms = $urandom;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) < 17) dly = $urandom_range(0, 60);
      else if ($urandom_range(0, 1) == 0) dly = $urandom;
      else dly = 32'h7FFF_FFF0 + $urandom_range(0, 31);
      ch = 4'($urandom_range(0, NCH - 1));
      if (pick < 35) op = CMD_TICK;
      else if (pick < 50) op = CMD_ON_DELAY;
      else if (pick < 62) op = CMD_OFF_DELAY;
      else if (pick < 72) op = CMD_ON_TIMED;
      else if (pick < 80) op = CMD_ABORT;
      else if (pick < 88) op = CMD_STATUS;
      else if (pick < 94) begin
        op = 3'($urandom_range(CMD_STATUS, CMD_ABORT));
        ch = 4'($urandom_range(NCH, 15));
      end else begin
        op = ($urandom_range(0, 1) == 0) ? CMD_BAD_LO : CMD_BAD_HI;
        ch = 4'($urandom_range(0, 15));
      end
      if (op == CMD_TICK) ch = 4'($urandom_range(0, 15));
      add_item(op, ch, ($urandom_range(0, 32) == 0) ? $urandom : clock_ms, dly,
               1'($urandom_range(0, 1)), (n % 300) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || cmd_bus.valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_beats.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));

    $display("Run covered %0d commands and ticks, %0d result beats checked",
             items_taken, beats_checked);
    $display("(%0d switch events, %0d error beats).", switch_beats, error_beats);
    $display("Receiver hold-offs: %0d, sender drain pauses: %0d, mismatches: %0d.",
             holds_done, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout waiting for the timer to finish.");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
